### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
// All forms are clocked on the given clock and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: invariant violated");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/chs_pkg.sv
`default_nettype none

package chs_pkg;

    // mode register values
    localparam logic [2:0] MODE_COPY = 3'd0;
    localparam logic [2:0] MODE_F3   = 3'd1;
    localparam logic [2:0] MODE_F2A  = 3'd2;
    localparam logic [2:0] MODE_F2B  = 3'd3;
    localparam logic [2:0] MODE_F5A  = 3'd4;
    localparam logic [2:0] MODE_F5B  = 3'd5;

    // job queue
    localparam int Q_DEPTH = 4;
    localparam int NUM_TAPS = 5;
    localparam int NUM_CELLS = 4;

    typedef enum logic [1:0] {
        KIND_COPY,
        KIND_F3,
        KIND_F2,
        KIND_F5
    } kind_t;

    // one window element: pixel word and its luma (77/150/29 weighted)
    typedef struct packed {
        logic [31:0] pix;
        logic [15:0] luma;
    } tap_t;

    // one pending result: kernel, taps (oldest first) and row-end mark
    typedef struct packed {
        kind_t                     kind;
        tap_t [NUM_TAPS-1:0]       taps;
        logic                      last;
    } job_t;

    function automatic logic [15:0] luma_of(input logic [31:0] p);
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        r = {8'd0, p[23:16]};
        g = {8'd0, p[15:8]};
        b = {8'd0, p[7:0]};
        return r * 16'd77 + g * 16'd150 + b * 16'd29;
    endfunction

    function automatic tap_t make_tap(input logic [31:0] p);
        tap_t t;
        t.pix  = p;
        t.luma = luma_of(p);
        return t;
    endfunction

    function automatic job_t make_job(input kind_t k, input tap_t a, input tap_t b,
                                      input tap_t c, input tap_t d, input tap_t e,
                                      input logic last);
        job_t j;
        j.kind    = k;
        j.taps[0] = a;
        j.taps[1] = b;
        j.taps[2] = c;
        j.taps[3] = d;
        j.taps[4] = e;
        j.last    = last;
        return j;
    endfunction

endpackage

`default_nettype wire

### rtl/core/chs_in_if.sv
`default_nettype none

interface chs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_in;
    logic        row_end;

    modport source (output valid, output pixel_in, output row_end, input ready);
    modport sink   (input valid, input pixel_in, input row_end, output ready);
endinterface

`default_nettype wire

### rtl/core/chs_out_if.sv
`default_nettype none

interface chs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        row_last;

    modport source (output valid, output pixel_out, output row_last, input ready);
    modport sink   (input valid, input pixel_out, input row_last, output ready);
endinterface

`default_nettype wire

### rtl/core/chs_cell.sv
`default_nettype none

// One window cell: loads the row's first pixel or takes its right neighbor.
module chs_cell
    import chs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic shift_en,
    input  wire logic load_en,
    input  wire tap_t cur,
    input  wire tap_t feed,
    output tap_t      q
);

    tap_t q_reg;
    tap_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (load_en)
        begin
            q_next = cur;
        end
        else if (shift_en)
        begin
            q_next = feed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

### rtl/core/chs_filt.sv
`default_nettype none

// Two-stage filter: stage 1 forms luma correction and tap averages,
// stage 2 (output register) adds, clamps and packs, or passes a copy job's pixel.
module chs_filt
    import chs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    input  wire job_t  job,
    output logic       job_pop,
    chs_out_if.source  out_ch
);

    // stage 1 registers
    logic              s1_valid_reg;
    logic              s1_copy_reg;
    logic [31:0]       s1_pix_reg;
    logic [2:0][7:0]   s1_avg_reg;
    logic signed [9:0] s1_yd_reg;
    logic              s1_last_reg;

    // output registers
    logic              o_valid_reg;
    logic [31:0]       o_pix_reg;
    logic              o_last_reg;

    logic              o_adv;
    logic              s1_free;

    logic signed [20:0] l0, l1, l2, l3, l4;
    logic signed [20:0] ysum;
    logic signed [9:0]  yd_next;
    logic [2:0][7:0]    avg_next;
    logic [10:0]        t;

    logic [2:0][7:0]    clamped;
    logic signed [9:0]  s;
    logic [31:0]        o_pix_next;

    assign o_adv   = !o_valid_reg || out_ch.ready;
    assign s1_free = !s1_valid_reg || o_adv;
    assign job_pop = job_valid && s1_free;

    // stage 1 arithmetic
    always_comb
    begin
        l0 = $signed({5'd0, job.taps[0].luma});
        l1 = $signed({5'd0, job.taps[1].luma});
        l2 = $signed({5'd0, job.taps[2].luma});
        l3 = $signed({5'd0, job.taps[3].luma});
        l4 = $signed({5'd0, job.taps[4].luma});
        ysum     = '0;
        yd_next  = '0;
        avg_next = '0;
        t        = '0;
        case (job.kind)
            KIND_F3:
            begin
                ysum    = 21'(2 * l1 - l0 - l2 + 512);
                yd_next = 10'(ysum >>> 10);
            end
            KIND_F2:
            begin
                ysum    = 21'(l0 - l1 + 256);
                yd_next = 10'(ysum >>> 9);
            end
            KIND_F5:
            begin
                ysum    = 21'(6 * l2 - l0 - 2 * (l1 + l3) - l4 + 1024);
                yd_next = 10'(ysum >>> 11);
            end
            default:
            begin
                ysum    = '0;
                yd_next = '0;
            end
        endcase
        for (int c = 0; c < 3; c++)
        begin
            case (job.kind)
                KIND_F3:
                begin
                    t = {3'd0, job.taps[0].pix[8*c +: 8]}
                      + {2'd0, job.taps[1].pix[8*c +: 8], 1'b0}
                      + {3'd0, job.taps[2].pix[8*c +: 8]} + 11'd2;
                    avg_next[c] = t[9:2];
                end
                KIND_F2:
                begin
                    t = {3'd0, job.taps[0].pix[8*c +: 8]}
                      + {3'd0, job.taps[1].pix[8*c +: 8]} + 11'd1;
                    avg_next[c] = t[8:1];
                end
                KIND_F5:
                begin
                    t = {3'd0, job.taps[0].pix[8*c +: 8]}
                      + {2'd0, job.taps[1].pix[8*c +: 8], 1'b0}
                      + {2'd0, job.taps[2].pix[8*c +: 8], 1'b0}
                      + {2'd0, job.taps[3].pix[8*c +: 8], 1'b0}
                      + {3'd0, job.taps[4].pix[8*c +: 8]} + 11'd4;
                    avg_next[c] = t[10:3];
                end
                default:
                begin
                    t = '0;
                    avg_next[c] = '0;
                end
            endcase
        end
    end

    // stage 2: correction, clamp, pack
    always_comb
    begin
        s = '0;
        for (int c = 0; c < 3; c++)
        begin
            s = s1_yd_reg + $signed({2'd0, s1_avg_reg[c]});
            if (s < 0)
            begin
                clamped[c] = 8'd0;
            end
            else if (s > 10'sd255)
            begin
                clamped[c] = 8'hff;
            end
            else
            begin
                clamped[c] = s[7:0];
            end
        end
        o_pix_next = s1_copy_reg ? s1_pix_reg : {8'd0, clamped[2], clamped[1], clamped[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= job_valid;
            end
            if (o_adv)
            begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            s1_copy_reg <= (job.kind == KIND_COPY);
            s1_pix_reg  <= job.taps[0].pix;
            s1_avg_reg  <= avg_next;
            s1_yd_reg   <= yd_next;
            s1_last_reg <= job.last;
        end
        if (o_adv && s1_valid_reg)
        begin
            o_pix_reg  <= o_pix_next;
            o_last_reg <= s1_last_reg;
        end
    end

    assign out_ch.valid     = o_valid_reg;
    assign out_ch.pixel_out = o_pix_reg;
    assign out_ch.row_last  = o_last_reg;

endmodule

`default_nettype wire

### rtl/core/chroma_smoother_horizontal.sv
// Channel   Dir  Payload                         Handshake
// in_ch     in   pixel_in[31:0], row_end         valid/ready
// out_ch    out  pixel_out[31:0], row_last       valid/ready
// cfg       in   cfg_wdata[2:0] (mode)           cfg_we, no stall
//
// Rate: one item per clock while in_ch.ready is high; an item becomes 0..3
// jobs in a 4-entry job queue that the filter drains one per clock while
// out_ch does not stall. in_ch.ready is high while the queue holds at most
// one job, so a row end can drop it. A job is written to the queue at the
// edge that takes its item, then passes filter stage 1 and the output register.
// Reset (async, rst_n low): mode = copy, row at start, queue and filter empty;
// out_ch.ready low holds the output register, then stage 1, then the queue.
`default_nettype none

`include "assert_macros.svh"

module chroma_smoother_horizontal
    import chs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_wdata,
    chs_in_if.sink          in_ch,
    chs_out_if.source       out_ch
);

    // mode register and row position
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [1:0] row_pos_reg;
    logic [1:0] row_pos_next;

    // job queue
    job_t       q_mem_reg [Q_DEPTH];
    logic [1:0] q_wr_ptr_reg;
    logic [1:0] q_wr_ptr_next;
    logic [1:0] q_rd_ptr_reg;
    logic [1:0] q_rd_ptr_next;
    logic [2:0] q_cnt_reg;
    logic [2:0] q_cnt_next;
    logic       q_pop;

    logic       acc;
    tap_t       cur;
    tap_t       w   [NUM_CELLS];
    tap_t       nw  [NUM_CELLS];
    tap_t       feed[NUM_CELLS];

    logic       is_f3;
    logic       is_f2;
    logic       is_f5;
    logic       is_copy;

    logic       pre_v;
    job_t       pre_job;
    logic [1:0] post_n;
    job_t       post_job0;
    job_t       post_job1;
    job_t       jobs[Q_DEPTH];
    logic [1:0] push_n;

    assign acc         = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (q_cnt_reg <= 3'd1);
    assign cur         = make_tap(in_ch.pixel_in);

    assign is_f3   = (mode_reg == MODE_F3);
    assign is_f2   = (mode_reg == MODE_F2A) || (mode_reg == MODE_F2B);
    assign is_f5   = (mode_reg == MODE_F5A) || (mode_reg == MODE_F5B);
    assign is_copy = !(is_f3 || is_f2 || is_f5);

    // window: a chain of cells, oldest at index 0, new pixel enters at 3
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        if (i == NUM_CELLS - 1)
        begin : g_tail
            assign feed[i] = cur;
        end
        else
        begin : g_body
            assign feed[i] = w[i+1];
        end
        chs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (acc),
            .load_en  (acc && (row_pos_reg == 2'd0)),
            .cur      (cur),
            .feed     (feed[i]),
            .q        (w[i])
        );
        // window as it stands once this item is in
        assign nw[i] = (row_pos_reg == 2'd0) ? cur : feed[i];
    end

    // jobs raised by one item: one the new pixel completes, then the
    // row-end flush (or the direct copy)
    always_comb
    begin
        pre_v     = 1'b0;
        pre_job   = '0;
        post_n    = 2'd0;
        post_job0 = '0;
        post_job1 = '0;

        if (row_pos_reg != 2'd0 && is_f3)
        begin
            pre_v   = 1'b1;
            pre_job = make_job(KIND_F3, w[2], w[3], cur, cur, cur, 1'b0);
        end
        else if (row_pos_reg != 2'd0 && is_f2)
        begin
            pre_v   = 1'b1;
            pre_job = make_job(KIND_F2, w[3], cur, cur, cur, cur, 1'b0);
        end
        else if (row_pos_reg >= 2'd2 && is_f5)
        begin
            pre_v   = 1'b1;
            pre_job = make_job(KIND_F5, w[0], w[1], w[2], w[3], cur, 1'b0);
        end

        if (is_copy)
        begin
            post_n    = 2'd1;
            post_job0 = make_job(KIND_COPY, cur, cur, cur, cur, cur, in_ch.row_end);
        end
        else if (in_ch.row_end)
        begin
            if (is_f3)
            begin
                post_n    = 2'd1;
                post_job0 = make_job(KIND_F3, nw[2], nw[3], nw[3], nw[3], nw[3], 1'b1);
            end
            else if (is_f2 || row_pos_reg == 2'd0)
            begin
                // two-tap last pixel and one-pixel five-tap rows pass through
                post_n    = 2'd1;
                post_job0 = make_job(KIND_COPY, cur, cur, cur, cur, cur, 1'b1);
            end
            else
            begin
                post_n    = 2'd2;
                post_job0 = make_job(KIND_F5, nw[0], nw[1], nw[2], nw[3], nw[3], 1'b0);
                post_job1 = make_job(KIND_F5, nw[1], nw[2], nw[3], nw[3], nw[3], 1'b1);
            end
        end

        jobs[0] = pre_v ? pre_job : post_job0;
        jobs[1] = pre_v ? post_job0 : post_job1;
        jobs[2] = post_job1;
        jobs[3] = '0;
        push_n  = acc ? (post_n + {1'b0, pre_v}) : 2'd0;
    end

    // queue control
    always_comb
    begin
        q_wr_ptr_next = q_wr_ptr_reg + push_n;
        q_rd_ptr_next = q_rd_ptr_reg + {1'b0, q_pop};
        q_cnt_next    = q_cnt_reg + {1'b0, push_n} - {2'd0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < Q_DEPTH; k++)
        begin
            if (2'(k - int'(q_wr_ptr_reg)) < push_n)
            begin
                q_mem_reg[k] <= jobs[2'(k - int'(q_wr_ptr_reg))];
            end
        end
    end

    // control registers
    always_comb
    begin
        mode_next    = cfg_we ? cfg_wdata : mode_reg;
        row_pos_next = row_pos_reg;
        if (acc)
        begin
            if (in_ch.row_end)
            begin
                row_pos_next = 2'd0;
            end
            else if (row_pos_reg != 2'd3)
            begin
                row_pos_next = row_pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_COPY;
            row_pos_reg  <= 2'd0;
            q_wr_ptr_reg <= 2'd0;
            q_rd_ptr_reg <= 2'd0;
            q_cnt_reg    <= 3'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            row_pos_reg  <= row_pos_next;
            q_wr_ptr_reg <= q_wr_ptr_next;
            q_rd_ptr_reg <= q_rd_ptr_next;
            q_cnt_reg    <= q_cnt_next;
        end
    end

    // filter pipeline and output register
    chs_filt u_filt (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_cnt_reg != 3'd0),
        .job       (q_mem_reg[q_rd_ptr_reg]),
        .job_pop   (q_pop),
        .out_ch    (out_ch)
    );

    // queue never overfills
    `ASSERT_ALWAYS(a_q_bound, clk, rst_n, q_cnt_reg <= 3'(Q_DEPTH))
    // a row end puts the next item at the row start
    `ASSERT_NEXT(a_row_restart, clk, rst_n, acc && in_ch.row_end, row_pos_reg == 2'd0)
    // first pixel of a row fills the whole window (left edge replication)
    `ASSERT_NEXT(a_edge_fill, clk, rst_n, acc && row_pos_reg == 2'd0, (w[0] == w[3]) && (w[1] == w[2]))
    // copy mode makes exactly one job per item
    `ASSERT_IMPLIES(a_copy_one, clk, rst_n, acc && is_copy, push_n == 2'd1)

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import chs_pkg::*;

    // spare register codes; the block treats both as copy
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 6;    // queue + filter + output reg, with margin
    localparam int TAIL_CYCLES  = 12;
    localparam int QUIET_LIMIT  = 2000; // cycles with no item taken on either side
    localparam int RANDOM_ITEMS = 295;
    localparam int CALM_AFTER   = 240;  // no idling on either side past this item

    // one output item
    typedef struct packed {
        logic [31:0] pix;
        logic        last;
    } px_word_t;

    // directed plan: a pixel, or a mode write (mode in word[2:0])
    typedef enum bit {ROW_PIXEL, ROW_MODE} plan_kind_t;

    typedef struct packed {
        plan_kind_t  kind;
        logic [31:0] word;
        logic        last;
        bit          typed;    // expected word typed in below
        logic [31:0] exp_word;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_wdata;

    chs_in_if  in_ch ();
    chs_out_if out_ch ();

    chroma_smoother_horizontal DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: register copy, pixel window, row position
    // ---------------------------------------------------------------
    logic [2:0]  mode_sel;
    logic [31:0] row_win [0:3];   // oldest first
    logic [1:0]  row_fill;        // pixels seen in row, saturates at 3

    px_word_t awaited_px [$];     // expected output items, oldest first
    px_word_t fresh_px [$];       // items produced by the last accepted pixel

    // typed-in expectation travels with the driven item
    bit          typed_on;
    logic [31:0] typed_word;

    bit idle_on;
    int fail_count;
    int quiet_cycles;

    plan_row_t plan [$];
    logic [2:0] mode_order [0:7] = '{MODE_F5B, MODE_SPARE7, MODE_COPY, MODE_F3,
                                     MODE_F2A, MODE_F2B, MODE_F5A, MODE_SPARE6};

    function automatic int luma_sum(input logic [31:0] p);
        return 77 * int'(p[23:16]) + 150 * int'(p[15:8]) + 29 * int'(p[7:0]);
    endfunction

    function automatic int chan8(input logic [31:0] p, input int k);
        return int'(p[8*k +: 8]);
    endfunction

    function automatic logic [7:0] sat8(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // luma correction is floor-divided: >>> on a signed int
    function automatic logic [31:0] smooth3(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
        int corr;
        int avg;
        int k;
        logic [31:0] w;
        w = '0;
        corr = (2 * luma_sum(b) - luma_sum(a) - luma_sum(c) + 512) >>> 10;
        for (k = 0; k < 3; k++)
        begin
            avg = (chan8(a, k) + 2 * chan8(b, k) + chan8(c, k) + 2) >> 2;
            w[8*k +: 8] = sat8(corr + avg);
        end
        return w;
    endfunction

    function automatic logic [31:0] smooth2(input logic [31:0] a, input logic [31:0] b);
        int corr;
        int avg;
        int k;
        logic [31:0] w;
        w = '0;
        corr = (luma_sum(a) - luma_sum(b) + 256) >>> 9;
        for (k = 0; k < 3; k++)
        begin
            avg = (chan8(a, k) + chan8(b, k) + 1) >> 1;
            w[8*k +: 8] = sat8(corr + avg);
        end
        return w;
    endfunction

    function automatic logic [31:0] smooth5(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d,
                                            input logic [31:0] e);
        int corr;
        int avg;
        int k;
        logic [31:0] w;
        w = '0;
        corr = (6 * luma_sum(c) - luma_sum(a) - 2 * (luma_sum(b) + luma_sum(d))
                - luma_sum(e) + 1024) >>> 11;
        for (k = 0; k < 3; k++)
        begin
            avg = (chan8(a, k) + chan8(e, k)
                   + 2 * (chan8(b, k) + chan8(c, k) + chan8(d, k)) + 4) >> 3;
            w[8*k +: 8] = sat8(corr + avg);
        end
        return w;
    endfunction

    // One accepted pixel: fills fresh_px with the items it completes.
    function automatic void advance_row(input logic [31:0] cur, input logic last);
        logic [1:0] pos;
        bit copy_mode;
        bit two_tap;
        bit five_tap;
        pos = row_fill;
        copy_mode = (mode_sel == MODE_COPY) || (mode_sel > MODE_F5B);
        two_tap   = (mode_sel == MODE_F2A) || (mode_sel == MODE_F2B);
        five_tap  = (mode_sel == MODE_F5A) || (mode_sel == MODE_F5B);
        fresh_px.delete();

        // result this pixel completes, taken before it enters the window
        if (pos >= 1 && mode_sel == MODE_F3)
            fresh_px.push_back('{smooth3(row_win[2], row_win[3], cur), 1'b0});
        else if (pos >= 1 && two_tap)
            fresh_px.push_back('{smooth2(row_win[3], cur), 1'b0});
        else if (pos >= 2 && five_tap)
            fresh_px.push_back('{smooth5(row_win[0], row_win[1], row_win[2],
                                         row_win[3], cur), 1'b0});

        // first pixel of a row fills the window: left-edge replication
        if (pos == 0)
        begin
            row_win[0] = cur;
            row_win[1] = cur;
            row_win[2] = cur;
            row_win[3] = cur;
        end
        else
        begin
            row_win[0] = row_win[1];
            row_win[1] = row_win[2];
            row_win[2] = row_win[3];
            row_win[3] = cur;
        end

        // copy mode passes the pixel on; a row end flushes the rest, with right-edge replication
        if (copy_mode)
            fresh_px.push_back('{cur, last});
        else if (last)
        begin
            if (mode_sel == MODE_F3)
                fresh_px.push_back('{smooth3(row_win[2], row_win[3], row_win[3]), 1'b1});
            else if (two_tap || pos == 0)
                fresh_px.push_back('{cur, 1'b1});
            else
            begin
                fresh_px.push_back('{smooth5(row_win[0], row_win[1], row_win[2],
                                             row_win[3], row_win[3]), 1'b0});
                fresh_px.push_back('{smooth5(row_win[1], row_win[2], row_win[3],
                                             row_win[3], row_win[3]), 1'b1});
            end
        end

        if (last)
            row_fill = 2'd0;
        else if (pos < 3)
            row_fill = pos + 2'd1;
    endfunction

    // Random pixel: each channel often at a rail so the clamps get hit.
    function automatic logic [31:0] random_pixel();
        logic [31:0] p;
        int k;
        p = $urandom;
        for (k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 5))
                0: p[8*k +: 8] = 8'h00;
                1: p[8*k +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return p;
    endfunction

    // ---------------------------------------------------------------
    // Sampling at the rising edge: register writes, input items feed
    // the predictor, output items are checked, quiet cycles counted.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        px_word_t want;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
                mode_sel = cfg_wdata;

            if (in_ch.valid && in_ch.ready)
            begin
                moved = 1'b1;
                advance_row(in_ch.pixel_in, in_ch.row_end);
                if (typed_on)
                    awaited_px.push_back('{typed_word, in_ch.row_end});
                else
                    foreach (fresh_px[i])
                        awaited_px.push_back(fresh_px[i]);
            end

            if (out_ch.valid && out_ch.ready)
            begin
                moved = 1'b1;
                if (awaited_px.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected item pixel_out=%h row_last=%b",
                             $time, out_ch.pixel_out, out_ch.row_last);
                end
                else
                begin
                    want = awaited_px.pop_front();
                    if (out_ch.pixel_out !== want.pix)
                    begin
                        fail_count++;
                        $display("%0t: pixel_out expected %h actual %h",
                                 $time, want.pix, out_ch.pixel_out);
                    end
                    if (out_ch.row_last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: row_last expected %b actual %b",
                                 $time, want.last, out_ch.row_last);
                    end
                end
            end

            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output side: ready is dropped in random stall bursts while idling
    // is on, otherwise held high.
    // ---------------------------------------------------------------
    initial
    begin : out_stall
        int n;
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 18);
                repeat (n)
                begin
                    @(negedge clk);
                    out_ch.ready <= 1'b0;
                end
            end
            else
            begin
                n = $urandom_range(1, 24);
                repeat (n)
                begin
                    @(negedge clk);
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Drive one pixel; returns at the edge where it is taken. valid stays
    // high so back-to-back items need no drop.
    task automatic send_pixel(input logic [31:0] pix, input logic last,
                              input bit typed, input logic [31:0] exp_word);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 18);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.pixel_in <= pix;
        in_ch.row_end  <= last;
        typed_on       <= typed;
        typed_word     <= exp_word;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Mode write: sender holds off until every expected item is out,
    // then lets the pipeline drain before the write.
    task automatic write_mode(input logic [2:0] m);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (awaited_px.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int sent;
        int phase;
        int rows;
        int len;
        int r;
        bit cut;

        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = MODE_COPY;
        in_ch.valid    = 1'b0;
        in_ch.pixel_in = '0;
        in_ch.row_end  = 1'b0;
        out_ch.ready   = 1'b0;
        typed_on       = 1'b0;
        typed_word     = '0;
        idle_on        = 1'b1;
        fail_count     = 0;
        quiet_cycles   = 0;
        mode_sel       = MODE_COPY;
        row_fill       = 2'd0;
        for (r = 0; r < 4; r++)
            row_win[r] = '0;

        // copy after reset: word passes through, top byte kept
        plan.push_back('{ROW_PIXEL, 32'hFFFFFFFF, 1'b0, 1'b1, 32'hFFFFFFFF});
        plan.push_back('{ROW_PIXEL, 32'h00000000, 1'b1, 1'b1, 32'h00000000});
        // three-tap: a one-pixel row filters with itself, top byte cleared
        plan.push_back('{ROW_MODE,  {29'd0, MODE_F3}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h12FF8001, 1'b1, 1'b1, 32'h00FF8001});
        plan.push_back('{ROW_PIXEL, 32'h00FF0000, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h0000FF00, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h000000FF, 1'b1, 1'b0, 32'h0});
        // two-tap: last pixel of a row, and a one-pixel row, copied
        plan.push_back('{ROW_MODE,  {29'd0, MODE_F2A}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h80FFFFFF, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'hFFFF00FF, 1'b1, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'hDEADBEEF, 1'b1, 1'b1, 32'hDEADBEEF});
        plan.push_back('{ROW_MODE,  {29'd0, MODE_F2B}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h11223344, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h55667788, 1'b1, 1'b0, 32'h0});
        // five-tap: one-pixel row copied, two-pixel row, long row
        plan.push_back('{ROW_MODE,  {29'd0, MODE_F5A}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'hCAFEF00D, 1'b1, 1'b1, 32'hCAFEF00D});
        plan.push_back('{ROW_PIXEL, 32'h00FFFFFF, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h00000000, 1'b1, 1'b0, 32'h0});
        plan.push_back('{ROW_MODE,  {29'd0, MODE_F5B}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h00FF0000, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'hFF00FF00, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h000000FF, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h00FFFFFF, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h00000000, 1'b1, 1'b0, 32'h0});
        // kernel switched inside a row: new kernel uses the old window
        plan.push_back('{ROW_MODE,  {29'd0, MODE_F3}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h00102030, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_MODE,  {29'd0, MODE_F5A}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h00405060, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h00708090, 1'b1, 1'b0, 32'h0});
        // spare codes behave as copy
        plan.push_back('{ROW_MODE,  {29'd0, MODE_SPARE6}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF});
        plan.push_back('{ROW_MODE,  {29'd0, MODE_SPARE7}, 1'b0, 1'b0, 32'h0});
        plan.push_back('{ROW_PIXEL, 32'h01020304, 1'b0, 1'b1, 32'h01020304});
        plan.push_back('{ROW_PIXEL, 32'h00000000, 1'b1, 1'b1, 32'h00000000});

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_MODE)
                write_mode(plan[i].word[2:0]);
            else
                send_pixel(plan[i].word, plan[i].last, plan[i].typed, plan[i].exp_word);
        end

        // Random part: phases of rows under one mode. First phases walk
        // every code, later ones pick at random. A phase may end mid-row
        // so the next mode picks up a half-filled window.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase < 8)
                write_mode(mode_order[phase]);
            else
                write_mode(3'($urandom_range(0, 7)));
            phase++;
            rows = $urandom_range(2, 8);
            for (int row = 0; row < rows && sent < RANDOM_ITEMS; row++)
            begin
                r = $urandom_range(0, 19);
                if (r < 3)
                    len = 1;
                else if (r < 17)
                    len = $urandom_range(2, 6);
                else
                    len = $urandom_range(7, 20);
                cut = (row == rows - 1) && ($urandom_range(0, 3) == 0);
                for (int k = 0; k < len; k++)
                begin
                    send_pixel(random_pixel(), (k == len - 1) && !cut, 1'b0, 32'h0);
                    sent++;
                    if (sent >= CALM_AFTER)
                        idle_on = 1'b0;
                end
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (awaited_px.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
